>>> src/gsm_pkg.sv
// Shared types, constants and mode tables for the square-window grayscale morphology.
// Used by gsm_cell and grayscale_square_morphology.
package gsm_pkg;
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 4096;
   localparam int MAX_RADIUS  = 7;
   localparam int STAGE_COUNT = 4;
   localparam int LINES       = 2 * MAX_RADIUS + 2;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
   localparam int LINE_BITS   = $clog2(LINES);
   localparam int ADDR_BITS   = LINE_BITS + COL_BITS;
   localparam int RAD_BITS    = 3;
   localparam int WCFG_BITS   = 11;
   localparam int HCFG_BITS   = 13;
   localparam int PIX_BITS    = 8;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_RADIUS       = 2'd2,
      REG_MODE         = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      CELL_IDLE, CELL_CHECK, CELL_READ, CELL_WAIT, CELL_DONE
   } cell_state_type;

   typedef enum logic [1:0] {
      TOP_IDLE, TOP_RUN, TOP_HOLD
   } top_state_type;

   typedef struct packed {
      logic [COL_BITS-1:0] w_m1;
      logic [ROW_BITS-1:0] h_m1;
      logic [RAD_BITS-1:0] r;
   } geom_type;

   typedef struct packed {
      logic                have;
      logic [PIX_BITS-1:0] pix;
      logic                eof;
   } token_type;

   function automatic logic [2:0] chain_len(input logic [2:0] m);
      logic [2:0] n;
      unique case (m)
         3'd2, 3'd3: n = 3'd2;
         3'd4, 3'd5: n = 3'd4;
         default:    n = 3'd1;
      endcase
      return n;
   endfunction

   function automatic logic [3:0] chain_max(input logic [2:0] m);
      logic [3:0] b;
      unique case (m)
         3'd1:    b = 4'h1;
         3'd2:    b = 4'h2;
         3'd3:    b = 4'h1;
         3'd4:    b = 4'h6;
         3'd5:    b = 4'h9;
         default: b = 4'h0;
      endcase
      return b;
   endfunction
endpackage

>>> src/gsm_cell.sv
// One filter stage: line store, input/output position counters, window min/max.
// Depends on gsm_pkg.
module gsm_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                enable,
   input  logic                use_max,
   input  gsm_pkg::geom_type   geom,
   input  gsm_pkg::token_type  tok_in,
   output logic                done,
   output gsm_pkg::token_type  tok_out
);
   import gsm_pkg::*;

   cell_state_type state_ff, state_in;
   logic [ROW_BITS-1:0] in_row_ff, out_row_ff, x_ff;
   logic [COL_BITS-1:0] in_col_ff, out_col_ff, y_ff;
   logic                in_done_ff, rd_valid_ff;
   logic [PIX_BITS-1:0] acc_ff, rd_data_ff;
   token_type           tok_ff;
   logic [PIX_BITS-1:0] mem [0:LINES*MAX_WIDTH-1];

   logic [ROW_BITS-1:0] i_c, x0_c, x1_c;
   logic [COL_BITS-1:0] j_c, y0_c, y1_c;
   logic [ROW_BITS:0]   isum_c;
   logic [COL_BITS:0]   jsum_c;
   logic                ready_c, last_c, eof_c;
   logic [PIX_BITS-1:0] acc_next_c;

   always_comb begin
      i_c    = (out_row_ff > geom.h_m1) ? geom.h_m1 : out_row_ff;
      j_c    = (out_col_ff > geom.w_m1) ? geom.w_m1 : out_col_ff;
      isum_c = {1'b0, i_c} + (ROW_BITS+1)'(geom.r);
      jsum_c = {1'b0, j_c} + (COL_BITS+1)'(geom.r);
      x1_c   = (isum_c > {1'b0, geom.h_m1}) ? geom.h_m1 : isum_c[ROW_BITS-1:0];
      y1_c   = (jsum_c > {1'b0, geom.w_m1}) ? geom.w_m1 : jsum_c[COL_BITS-1:0];
      x0_c   = (i_c > ROW_BITS'(geom.r)) ? i_c - ROW_BITS'(geom.r) : '0;
      y0_c   = (j_c > COL_BITS'(geom.r)) ? j_c - COL_BITS'(geom.r) : '0;
      ready_c = in_done_ff || (in_row_ff > x1_c) ||
                (in_row_ff == x1_c && in_col_ff > y1_c);
      last_c  = (x_ff == x1_c) && (y_ff == y1_c);
      eof_c   = (out_col_ff >= geom.w_m1) && (out_row_ff >= geom.h_m1);
      acc_next_c = acc_ff;
      if (rd_valid_ff) begin
         if (use_max ? (rd_data_ff > acc_ff) : (rd_data_ff < acc_ff)) begin
            acc_next_c = rd_data_ff;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CELL_IDLE:  if (start) state_in = enable ? CELL_CHECK : CELL_DONE;
         CELL_CHECK: state_in = ready_c ? CELL_READ : CELL_DONE;
         CELL_READ:  if (last_c) state_in = CELL_WAIT;
         CELL_WAIT:  state_in = CELL_DONE;
         CELL_DONE:  state_in = CELL_IDLE;
         default:    state_in = CELL_IDLE;
      endcase
   end

   always_comb begin
      done    = (state_ff == CELL_DONE);
      tok_out = tok_ff;
   end

   always_ff @(posedge clock) begin
      if (state_ff == CELL_IDLE && start && enable && tok_in.have && !in_done_ff) begin
         mem[{in_row_ff[LINE_BITS-1:0], in_col_ff}] <= tok_in.pix;
      end
      if (state_ff == CELL_READ) begin
         rd_data_ff <= mem[{x_ff[LINE_BITS-1:0], y_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= CELL_IDLE;
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         in_done_ff  <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= (state_ff == CELL_READ);
         unique case (state_ff)
            CELL_IDLE: begin
               if (start) begin
                  tok_ff <= tok_in;
                  if (enable && tok_in.have && !in_done_ff) begin
                     if (in_col_ff >= geom.w_m1) begin
                        in_col_ff <= '0;
                        if (in_row_ff >= geom.h_m1) in_done_ff <= 1'b1;
                        else in_row_ff <= in_row_ff + 1'b1;
                     end else begin
                        in_col_ff <= in_col_ff + 1'b1;
                     end
                  end
               end
            end
            CELL_CHECK: begin
               x_ff   <= x0_c;
               y_ff   <= y0_c;
               acc_ff <= use_max ? '0 : '1;
               tok_ff <= '{have: 1'b0, pix: tok_ff.pix, eof: 1'b0};
            end
            CELL_READ: begin
               acc_ff <= acc_next_c;
               if (!last_c) begin
                  if (y_ff == y1_c) begin
                     y_ff <= y0_c;
                     x_ff <= x_ff + 1'b1;
                  end else begin
                     y_ff <= y_ff + 1'b1;
                  end
               end
            end
            CELL_WAIT: begin
               tok_ff <= '{have: 1'b1, pix: acc_next_c, eof: eof_c};
               if (out_col_ff >= geom.w_m1) begin
                  out_col_ff <= '0;
                  if (out_row_ff >= geom.h_m1) begin
                     out_row_ff <= '0;
                     in_row_ff  <= '0;
                     in_col_ff  <= '0;
                     in_done_ff <= 1'b0;
                  end else begin
                     out_row_ff <= out_row_ff + 1'b1;
                  end
               end else begin
                  out_col_ff <= out_col_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end
endmodule

>>> src/grayscale_square_morphology.sv
// Per request each active stage checks its window and, when it emits a pixel, scans the
// rows*cols window before it is done; inactive stages go straight to done.
// One request at a time; the next is taken in the cycle after the last stage finishes,
// later while a result waits; the window scan in each stage sets the rate.
// Synchronous active-high reset clears counters and control; line stores are not cleared.
// Top level: configuration registers, chain of four gsm_cell stages, output register.
// Depends on gsm_pkg and gsm_cell.
module grayscale_square_morphology (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_op,
   input  logic [gsm_pkg::PIX_BITS-1:0]   req_pixel_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [gsm_pkg::PIX_BITS-1:0]   rsp_pixel_out,
   output logic                           rsp_end_of_frame,
   input  logic                           csr_we,
   input  logic [1:0]                     csr_index,
   input  logic [gsm_pkg::HCFG_BITS-1:0]  csr_wdata
);
   import gsm_pkg::*;

   logic [WCFG_BITS-1:0] width_ff;
   logic [HCFG_BITS-1:0] height_ff;
   logic [RAD_BITS-1:0]  radius_ff;
   logic [2:0]           mode_ff;
   top_state_type        state_ff, state_in;
   token_type            pend_ff;
   logic                 rsp_valid_ff;
   logic [PIX_BITS-1:0]  rsp_pix_ff;
   logic                 rsp_eof_ff;

   geom_type             geom_c;
   logic                 accept_c, slot_free_c;
   logic                 load_run_c, load_hold_c;
   logic [STAGE_COUNT:0] start_c;
   logic [STAGE_COUNT-1:0] done_c;
   token_type            tok_c [0:STAGE_COUNT];
   logic [2:0]           n_c;
   logic [3:0]           maxb_c;

   always_comb begin
      if (width_ff == '0) geom_c.w_m1 = '0;
      else if (width_ff > WCFG_BITS'(MAX_WIDTH)) geom_c.w_m1 = COL_BITS'(MAX_WIDTH - 1);
      else geom_c.w_m1 = COL_BITS'(width_ff - 1'b1);
      if (height_ff == '0) geom_c.h_m1 = '0;
      else if (height_ff > HCFG_BITS'(MAX_HEIGHT)) geom_c.h_m1 = ROW_BITS'(MAX_HEIGHT - 1);
      else geom_c.h_m1 = ROW_BITS'(height_ff - 1'b1);
      geom_c.r = (radius_ff > RAD_BITS'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS) : radius_ff;
      n_c    = chain_len(mode_ff);
      maxb_c = chain_max(mode_ff);
   end

   assign accept_c    = req_valid && req_ready;
   assign slot_free_c = !rsp_valid_ff || rsp_ready;
   assign start_c[0]  = accept_c;
   assign tok_c[0]    = '{have: !req_op, pix: req_pixel_in, eof: 1'b0};
   assign load_run_c  = (state_ff == TOP_RUN) && start_c[STAGE_COUNT] &&
                        tok_c[STAGE_COUNT].have && slot_free_c;
   assign load_hold_c = (state_ff == TOP_HOLD) && slot_free_c;

   for (genvar s = 0; s < STAGE_COUNT; s++) begin : g_cell
      gsm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .start   (start_c[s]),
         .enable  (32'(s) < 32'(n_c)),
         .use_max (maxb_c[s]),
         .geom    (geom_c),
         .tok_in  (tok_c[s]),
         .done    (done_c[s]),
         .tok_out (tok_c[s+1])
      );
      assign start_c[s+1] = done_c[s];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TOP_IDLE: if (accept_c) state_in = TOP_RUN;
         TOP_RUN: begin
            if (start_c[STAGE_COUNT]) begin
               state_in = (tok_c[STAGE_COUNT].have && !slot_free_c) ? TOP_HOLD : TOP_IDLE;
            end
         end
         TOP_HOLD: if (slot_free_c) state_in = TOP_IDLE;
         default: state_in = TOP_IDLE;
      endcase
   end

   always_comb begin
      req_ready        = (state_ff == TOP_IDLE);
      rsp_valid        = rsp_valid_ff;
      rsp_pixel_out    = rsp_pix_ff;
      rsp_end_of_frame = rsp_eof_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WCFG_BITS'(1024);
         height_ff    <= HCFG_BITS'(1024);
         radius_ff    <= RAD_BITS'(1);
         mode_ff      <= '0;
         state_ff     <= TOP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (reg_index_type'(csr_index))
               REG_FRAME_WIDTH:  width_ff  <= csr_wdata[WCFG_BITS-1:0];
               REG_FRAME_HEIGHT: height_ff <= csr_wdata;
               REG_RADIUS:       radius_ff <= csr_wdata[RAD_BITS-1:0];
               REG_MODE:         mode_ff   <= csr_wdata[2:0];
               default: begin
               end
            endcase
         end
         if (load_run_c || load_hold_c) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (load_run_c) begin
            rsp_pix_ff <= tok_c[STAGE_COUNT].pix;
            rsp_eof_ff <= tok_c[STAGE_COUNT].eof;
         end else if (load_hold_c) begin
            rsp_pix_ff <= pend_ff.pix;
            rsp_eof_ff <= pend_ff.eof;
         end
         if (state_ff == TOP_RUN && start_c[STAGE_COUNT] && tok_c[STAGE_COUNT].have &&
             !slot_free_c) begin
            pend_ff <= tok_c[STAGE_COUNT];
         end
      end
   end
endmodule

>>> tb/morph_tb_pkg.sv
// Request and mode codes shared by the morphology testbench files.
// No dependencies; compiled before morph_checker and testbench.
package morph_tb_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } morph_op_type;

   typedef enum logic [2:0] {
      MODE_ERODE      = 3'd0,
      MODE_DILATE     = 3'd1,
      MODE_OPEN       = 3'd2,
      MODE_CLOSE      = 3'd3,
      MODE_OPEN_CLOSE = 3'd4,
      MODE_CLOSE_OPEN = 3'd5,
      MODE_SPARE6     = 3'd6,
      MODE_SPARE7     = 3'd7
   } morph_mode_type;
endpackage

>>> tb/morph_checker.sv
// Watches request, response and register ports of grayscale_square_morphology,
// predicts each filtered pixel with its own stage chain and compares in order.
// Depends on gsm_pkg and morph_tb_pkg.
module morph_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_pixel_in,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_pixel_out,
   input  logic        rsp_end_of_frame,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata,
   output int          failures,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import gsm_pkg::*;
   import morph_tb_pkg::*;

   localparam int NSTAGE = 4;
   localparam int NLINE  = 16;
   localparam int MAXW   = 1024;

   typedef struct {
      logic [7:0] pix;
      logic       eof;
   } filtered_pixel_type;

   filtered_pixel_type expected_pixels[$];
   logic [7:0]  line_mem [NSTAGE][NLINE][MAXW];
   int unsigned in_row [NSTAGE];
   int unsigned in_col [NSTAGE];
   int unsigned out_row [NSTAGE];
   int unsigned out_col [NSTAGE];
   bit          in_done [NSTAGE];
   logic [10:0] cfg_width;
   logic [12:0] cfg_height;
   logic [2:0]  cfg_radius;
   morph_mode_type cfg_mode;
   int          fail_count;

   assign failures = fail_count;

   function automatic int stages_of(morph_mode_type m);
      case (m)
         MODE_OPEN, MODE_CLOSE:           return 2;
         MODE_OPEN_CLOSE, MODE_CLOSE_OPEN: return 4;
         default:                         return 1;
      endcase
   endfunction

   function automatic bit stage_takes_max(morph_mode_type m, int s);
      case (m)
         MODE_DILATE:     return s == 0;
         MODE_OPEN:       return s == 1;
         MODE_CLOSE:      return s == 0;
         MODE_OPEN_CLOSE: return s == 1 || s == 2;
         MODE_CLOSE_OPEN: return s == 0 || s == 3;
         default:         return 0;
      endcase
   endfunction

   function automatic int unsigned lesser(int unsigned a, int unsigned b);
      return a < b ? a : b;
   endfunction

   function automatic void morph_step(input logic flush, input logic [7:0] pix_in,
                                      output logic emit, output logic [7:0] pix,
                                      output logic eof);
      int unsigned w, h, r, i, j, nr, nc, x0, x1, y0, y1;
      int n;
      bit have, ready, use_max;
      logic [7:0] v, acc;
      w = (cfg_width == 0) ? 1 : (cfg_width > MAXW ? MAXW : cfg_width);
      h = (cfg_height == 0) ? 1 : (cfg_height > 4096 ? 4096 : cfg_height);
      r = cfg_radius;
      n = stages_of(cfg_mode);
      have = !flush;
      v = pix_in;
      eof = 0;
      for (int s = 0; s < n; s++) begin
         if (have && !in_done[s]) begin
            if (in_col[s] < MAXW) line_mem[s][in_row[s] % NLINE][in_col[s]] = v;
            if (in_col[s] + 1 >= w) begin
               in_col[s] = 0;
               if (in_row[s] + 1 >= h) in_done[s] = 1;
               else in_row[s]++;
            end else begin
               in_col[s]++;
            end
         end
         have = 0;
         eof = 0;
         i = lesser(out_row[s], h - 1);
         j = lesser(out_col[s], w - 1);
         nr = lesser(i + r, h - 1);
         nc = lesser(j + r, w - 1);
         ready = in_done[s] || in_row[s] > nr || (in_row[s] == nr && in_col[s] > nc);
         if (ready) begin
            use_max = stage_takes_max(cfg_mode, s);
            x0 = i > r ? i - r : 0;
            x1 = nr;
            y0 = j > r ? j - r : 0;
            y1 = nc;
            acc = use_max ? 8'd0 : 8'd255;
            for (int unsigned x = x0; x <= x1; x++)
               for (int unsigned y = y0; y <= y1; y++)
                  if (use_max ? line_mem[s][x % NLINE][y] > acc
                              : line_mem[s][x % NLINE][y] < acc)
                     acc = line_mem[s][x % NLINE][y];
            v = acc;
            have = 1;
            if (out_col[s] + 1 >= w) begin
               out_col[s] = 0;
               if (out_row[s] + 1 >= h) begin
                  eof = 1;
                  in_row[s] = 0;
                  in_col[s] = 0;
                  out_row[s] = 0;
                  in_done[s] = 0;
               end else begin
                  out_row[s]++;
               end
            end else begin
               out_col[s]++;
            end
         end
      end
      emit = have;
      pix = v;
   endfunction

   always @(posedge clock) begin
      filtered_pixel_type exp_px;
      logic emit, eof;
      logic [7:0] pix;
      if (reset) begin
         expected_pixels.delete();
         for (int s = 0; s < NSTAGE; s++) begin
            in_row[s] = 0;
            in_col[s] = 0;
            out_row[s] = 0;
            out_col[s] = 0;
            in_done[s] = 0;
         end
         cfg_width = 11'd1024;
         cfg_height = 13'd1024;
         cfg_radius = 3'd1;
         cfg_mode = MODE_ERODE;
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               REG_FRAME_WIDTH:  cfg_width = csr_wdata[10:0];
               REG_FRAME_HEIGHT: cfg_height = csr_wdata;
               REG_RADIUS:       cfg_radius = csr_wdata[2:0];
               REG_MODE:         cfg_mode = morph_mode_type'(csr_wdata[2:0]);
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("response with no request outstanding: pixel_out %0d",
                      rsp_pixel_out);
               fail_count++;
            end else begin
               exp_px = expected_pixels.pop_front();
               if (rsp_pixel_out !== exp_px.pix) begin
                  $error("pixel_out: expected %0d, actual %0d", exp_px.pix, rsp_pixel_out);
                  fail_count++;
               end
               if (rsp_end_of_frame !== exp_px.eof) begin
                  $error("end_of_frame: expected %0d, actual %0d",
                         exp_px.eof, rsp_end_of_frame);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            morph_step(req_op == OP_FLUSH, req_pixel_in, emit, pix, eof);
            if (emit) begin
               exp_px.pix = pix;
               exp_px.eof = eof;
               expected_pixels = {expected_pixels, exp_px};
            end
         end
      end
      pending <= expected_pixels.size();
   end
endmodule

>>> tb/testbench.sv
// Top of the morphology testbench: clock, reset, register writes, frame stimulus
// and verdict. Depends on gsm_pkg, morph_tb_pkg, morph_checker and the block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import gsm_pkg::*;
   import morph_tb_pkg::*;

   localparam int SETTLE = 1200;
   localparam longint LIMIT = 40_000_000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_op = OP_PIXEL;
   logic [7:0]  req_pixel_in = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [7:0]  rsp_pixel_out;
   logic        rsp_end_of_frame;
   logic        csr_we = 0;
   logic [1:0]  csr_index = REG_FRAME_WIDTH;
   logic [12:0] csr_wdata = 0;
   int          failures, pending;
   int          frames_out = 0;
   int          requests = 0;
   longint      cycles = 0;
   bit          stalls_on = 1;

   grayscale_square_morphology dut (.*);
   morph_checker checker_i (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= stalls_on ? ($urandom_range(99) >= 37) : 1'b1;
      if (!reset && rsp_valid && rsp_ready && rsp_end_of_frame) frames_out++;
   end

   task automatic send_request(input morph_op_type op, input logic [7:0] pix);
      while (stalls_on && $urandom_range(99) < 37) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_op <= op;
      req_pixel_in <= pix;
      do @(posedge clock); while (!req_ready);
      requests++;
   endtask

   task automatic write_config(input logic [12:0] w, input logic [12:0] h,
                               input logic [12:0] r, input logic [12:0] m);
      reg_index_type idx[4];
      logic [12:0] val[4];
      idx = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_RADIUS, REG_MODE};
      val = '{w, h, r, m};
      req_valid <= 0;
      for (int k = 0; k < 4; k++) begin
         csr_we <= 1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         @(posedge clock);
      end
      csr_we <= 0;
   endtask

   function automatic logic [7:0] pick_pixel();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         default: return $urandom_range(255);
      endcase
   endfunction

   task automatic run_frame(input logic [12:0] w, input logic [12:0] h, input logic [12:0] r,
                            input logic [12:0] m, input int flush_pct);
      int unsigned we, he;
      int target;
      we = (w[10:0] == 0) ? 1 : (w[10:0] > 1024 ? 1024 : w[10:0]);
      he = (h == 0) ? 1 : (h > 4096 ? 4096 : h);
      write_config(w, h, r, m);
      target = frames_out + 1;
      for (int unsigned k = 0; k < we * he; k++) begin
         if ($urandom_range(99) < flush_pct) send_request(OP_FLUSH, $urandom_range(255));
         send_request(OP_PIXEL, pick_pixel());
      end
      // stage 0 still has outputs pending here, so this request's pixel is not stored
      if (r[2:0] != 0 && we >= 2 && he >= 2 && $urandom_range(1))
         send_request(OP_PIXEL, $urandom_range(255));
      while (frames_out < target) send_request(OP_FLUSH, $urandom_range(255));
      req_valid <= 0;
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      int frame_no;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      run_frame(13'd0, 13'd0, 13'd0, MODE_ERODE, 0);
      run_frame(13'd3, 13'd2, 13'd7, MODE_SPARE6, 30);
      run_frame(13'd4, 13'd3, 13'd1, MODE_SPARE7, 0);
      for (int m = MODE_ERODE; m <= MODE_CLOSE_OPEN; m++)
         run_frame(13'd3, 13'd3, 13'd1, m, 10);

      frame_no = 0;
      while (requests < 1050) begin
         stalls_on = !(frame_no >= 4 && frame_no < 10);
         if ($urandom_range(9) == 0)
            run_frame($urandom_range(17, 40), $urandom_range(1, 3), $urandom_range(7),
                      $urandom_range(7), $urandom_range(20));
         else
            run_frame($urandom_range(1, 16), $urandom_range(1, 8), $urandom_range(7),
                      $urandom_range(7), $urandom_range(20));
         frame_no++;
      end
      stalls_on = 1;

      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
